/* rtl/ir_adc_smoothing_distance_unit_macros.svh */
// assertion helpers used by the checker file
`ifndef IR_ADC_SMOOTHING_DISTANCE_UNIT_MACROS_SVH
`define IR_ADC_SMOOTHING_DISTANCE_UNIT_MACROS_SVH

// checked outside reset only
`define IRADS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define IRADS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/irads_pkg.sv */
`default_nettype none
package irads_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int WINDOW_DEF   = 10;

  localparam int CODE_W     = 12;
  localparam int VOLTS_W    = 19;
  localparam int ALPHA_W    = 9;
  localparam int COEF_W     = 32;
  localparam int DIST_W     = 24;
  localparam int T_W        = VOLTS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int VOLTS_FULL = 327680;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTIC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd5;

  typedef struct packed {
    logic signed [COEF_W-1:0] quartic;
    logic signed [COEF_W-1:0] cubic;
    logic signed [COEF_W-1:0] square;
    logic signed [COEF_W-1:0] linear;
    logic signed [COEF_W-1:0] offset;
  } coef_set_t;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 9'd102;
  localparam coef_set_t COEF_RST = '{
    quartic: 32'sd483000,
    cubic:   -32'sd4262173,
    square:  32'sd13810493,
    linear:  -32'sd20714507,
    offset:  32'sd14478259
  };

  typedef struct packed {
    logic           start;
    logic [T_W-1:0] t;
  } poly_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIST_W-1:0] distance;
  } poly_rsp_t;

endpackage
`default_nettype wire

/* rtl/irads_if.sv */
`default_nettype none
interface irads_sample_if
  import irads_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              channel;
  logic [CODE_W-1:0] adc_code;

  modport source (output valid, channel, adc_code, input ready);
  modport sink   (input valid, channel, adc_code, output ready);
endinterface

interface irads_result_if
  import irads_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     out_channel;
  logic [VOLTS_W-1:0]       smoothed_volts;
  logic signed [DIST_W-1:0] distance;

  modport source (output valid, out_channel, smoothed_volts, distance, input ready);
  modport sink   (input valid, out_channel, smoothed_volts, distance, output ready);
endinterface
`default_nettype wire

/* rtl/irads_poly.sv */
`default_nettype none
module irads_poly
  import irads_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  poly_req_t req,
  input  coef_set_t coef,
  output poly_rsp_t rsp
);

  localparam int ACC_W      = 43;
  localparam int LO_W       = 22;
  localparam int HI_W       = ACC_W - LO_W;
  localparam int PLO_W      = LO_W + T_W + 1;
  localparam int PHI_W      = HI_W + T_W + 1;
  localparam int FRAC_W     = 16;
  localparam int SPLIT_SH   = LO_W - FRAC_W;
  localparam int HALF_FRAC  = 1 << (FRAC_W - 1);
  localparam int DIST_FRAC  = 8;
  localparam int DIST_HALF  = 1 << (DIST_FRAC - 1);
  localparam int DIST_MAX_I = 8388607;
  localparam int DIST_MIN_I = -8388608;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_MUL  = 4'b0010,
    P_ADD  = 4'b0100,
    P_RND  = 4'b1000
  } poly_state_t;

  poly_state_t              state;
  logic [1:0]               step;
  logic                     done;
  logic signed [DIST_W-1:0] dist_reg;
  logic signed [ACC_W-1:0]  acc;
  logic [T_W-1:0]           t_reg;
  logic [PLO_W-1:0]         p_lo;
  logic signed [PHI_W-1:0]  p_hi;

  logic signed [HI_W-1:0]   hi_part;
  logic signed [T_W:0]      t_s;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [ACC_W-1:0]  term_hi;
  logic signed [ACC_W-1:0]  term_lo;
  logic signed [ACC_W-1:0]  term_c;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;

  assign hi_part = acc[ACC_W-1:LO_W];
  assign t_s     = signed'({1'b0, t_reg});

  always_comb begin
    case (step)
      2'd0:    coef_sel = coef.cubic;
      2'd1:    coef_sel = coef.square;
      2'd2:    coef_sel = coef.linear;
      default: coef_sel = coef.offset;
    endcase
  end

  // high part carries no bits below the rounding point, so the shifts split cleanly
  assign term_hi = ACC_W'(p_hi) <<< SPLIT_SH;
  assign term_lo = signed'(ACC_W'(p_lo >> FRAC_W));
  assign term_c  = ACC_W'(coef_sel);
  assign rnd     = acc + ACC_W'(DIST_HALF);
  assign shifted = rnd >>> DIST_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        P_IDLE: begin
          if (req.start) begin
            step  <= '0;
            state <= P_MUL;
          end
        end
        P_MUL: state <= P_ADD;
        P_ADD: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= P_RND;
          end else begin
            state <= P_MUL;
          end
        end
        P_RND: begin
          done  <= 1'b1;
          state <= P_IDLE;
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == P_IDLE && req.start) begin
      acc   <= ACC_W'(coef.quartic);
      t_reg <= req.t;
    end
    if (state == P_MUL) begin
      p_lo <= PLO_W'(acc[LO_W-1:0]) * PLO_W'(t_reg) + PLO_W'(HALF_FRAC);
      p_hi <= hi_part * t_s;
    end
    if (state == P_ADD) begin
      acc <= term_hi + term_lo + term_c;
    end
    if (state == P_RND) begin
      if (shifted > ACC_W'(DIST_MAX_I)) begin
        dist_reg <= DIST_W'(DIST_MAX_I);
      end else if (shifted < ACC_W'(DIST_MIN_I)) begin
        dist_reg <= DIST_W'(DIST_MIN_I);
      end else begin
        dist_reg <= DIST_W'(shifted);
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.distance = dist_reg;

endmodule
`default_nettype wire

/* rtl/ir_adc_smoothing_distance_unit.sv */
// IR distance sensor conditioning, one converter sample in, one distance out.
// sample channel: valid/ready transfer of channel and adc_code. result channel:
// valid/ready transfer of out_channel, smoothed_volts (Q3.16) and distance
// (signed, 1/256 units, saturated). The user must write registers through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block
// itself does not enforce this. One sample is processed at a time: channel
// record read, low-pass update, ring read and write-back, the divide by the
// window length, then the quartic in a shared two-partial-product multiplier,
// a multiply and an add per Horner step. The result becomes valid as the block
// returns to idle, so a new sample is taken only after the last is through.
// The result sits in an output register; a stalled receiver lets the next
// sample in, and that one then waits at the end until the register is free.
// Reset clears registers to their defaults and empties filter and ring state
// at once (per-channel valid and ring-full flags, no clearing pass).
// A sample for a channel beyond CHANNELS is taken and dropped.
`default_nettype none
module ir_adc_smoothing_distance_unit
  import irads_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int WINDOW   = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  irads_sample_if.sink          sample,
  irads_result_if.source        result
);

  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WA_W     = (CHANNELS * WINDOW > 1) ? $clog2(CHANNELS * WINDOW) : 1;
  localparam int SUM_W    = $clog2(WINDOW * VOLTS_FULL + 1);
  localparam int X_W      = $clog2(WINDOW * VOLTS_FULL + WINDOW / 2 + 1);
  localparam int DIV_S    = X_W;
  localparam int DIV_MW   = DIV_S + 1;
  localparam int PROD_W   = X_W + DIV_MW;
  localparam logic [DIV_MW-1:0] DIV_M = DIV_MW'((64'd1 << DIV_S) / WINDOW);
  localparam int LP_W     = VOLTS_W + ALPHA_W;
  localparam int ALPHA_ONE  = 256;
  localparam int ALPHA_SH   = 8;
  localparam int ALPHA_HALF = 128;
  localparam int ADC_SH     = 12;
  localparam int ADC_FULL   = 4095;
  localparam int ADC_HALF   = 2047;
  localparam int VOLTS_LSB  = 80;

  typedef struct packed {
    logic [VOLTS_W-1:0] lp;
    logic [SUM_W-1:0]   sum;
    logic [POS_W-1:0]   pos;
  } chan_rec_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDCH  = 7'b0000010,
    S_RDWIN = 7'b0000100,
    S_DIV1  = 7'b0001000,
    S_DIV2  = 7'b0010000,
    S_POLY  = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_t;

  // code * 327680 / 4095 rounded: 327680 = 80 * 4095 + 80, so only a small
  // quotient of at most 80 is left over
  function automatic logic [VOLTS_W-1:0] code_to_volts(input logic [CODE_W-1:0] code);
    logic [VOLTS_W-1:0] base;
    logic [VOLTS_W-1:0] y;
    logic [VOLTS_W-ADC_SH-1:0] q0;
    logic [ADC_SH:0] r;
    base = VOLTS_W'(code) * VOLTS_W'(VOLTS_LSB);
    y    = base + VOLTS_W'(ADC_HALF);
    q0   = y[VOLTS_W-1:ADC_SH];
    r    = {1'b0, y[ADC_SH-1:0]} + (ADC_SH+1)'(q0);
    return base + VOLTS_W'(q0) + VOLTS_W'(r >= (ADC_SH+1)'(ADC_FULL));
  endfunction

  state_t                   state;
  logic [ALPHA_W-1:0]       alpha;
  coef_set_t                coef;
  logic [CHANNELS-1:0]      chan_valid;
  logic [CHANNELS-1:0]      ring_full;
  logic                     out_valid;

  logic                     ch_bit;
  logic [CH_AW-1:0]         ch_idx;
  logic [VOLTS_W-1:0]       volts_reg;
  logic [VOLTS_W-1:0]       lp_reg;
  logic [SUM_W-1:0]         sum_old;
  logic [POS_W-1:0]         pos_new;
  logic [WA_W-1:0]          win_addr;
  logic [SUM_W-1:0]         sum_reg;
  logic [PROD_W-1:0]        prod_reg;
  logic [T_W-1:0]           avg_reg;
  logic                     out_ch;
  logic [VOLTS_W-1:0]       out_volts;
  logic signed [DIST_W-1:0] out_dist;

  chan_rec_t                chan_mem [CHANNELS];
  logic [VOLTS_W-1:0]       win_mem  [CHANNELS*WINDOW];
  chan_rec_t                chan_rd;
  logic [VOLTS_W-1:0]       win_rd;

  logic                     sample_fire;
  logic                     in_ok;
  logic [CH_AW-1:0]         in_idx;
  chan_rec_t                rec_cur;
  logic [ALPHA_W-1:0]       alpha_eff;
  logic [LP_W-1:0]          lp_sum;
  logic [VOLTS_W-1:0]       lp_new;
  logic [POS_W-1:0]         pos_next;
  logic [WA_W-1:0]          win_addr_next;
  logic [VOLTS_W-1:0]       old_val;
  logic [SUM_W-1:0]         sum_new;
  logic [X_W-1:0]           div_x;
  logic [T_W-1:0]           q_est;
  logic [X_W-1:0]           div_r;
  logic [T_W-1:0]           avg_next;
  logic                     out_free;
  logic                     out_load;
  poly_req_t                poly_req;
  poly_rsp_t                poly_rsp;

  assign sample.ready = (state == S_IDLE);
  assign sample_fire  = sample.valid && sample.ready;
  assign in_ok        = (int'(sample.channel) < CHANNELS);
  assign in_idx       = CH_AW'(sample.channel);

  // entries never written since reset read as zero
  assign rec_cur   = chan_valid[ch_idx] ? chan_rd : '0;
  assign alpha_eff = (alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha;
  assign lp_sum    = LP_W'(alpha_eff) * LP_W'(volts_reg)
                   + LP_W'(ALPHA_W'(ALPHA_ONE) - alpha_eff) * LP_W'(rec_cur.lp)
                   + LP_W'(ALPHA_HALF);
  assign lp_new    = lp_sum[ALPHA_SH +: VOLTS_W];
  assign pos_next  = (rec_cur.pos == POS_W'(WINDOW - 1)) ? '0 : rec_cur.pos + POS_W'(1);
  assign win_addr_next = WA_W'(ch_idx) * WA_W'(WINDOW) + WA_W'(pos_next);

  assign old_val  = ring_full[ch_idx] ? win_rd : '0;
  assign sum_new  = sum_old - SUM_W'(old_val) + SUM_W'(lp_reg);

  // reciprocal estimate is low by at most one
  assign div_x    = X_W'(sum_reg) + X_W'(WINDOW / 2);
  assign q_est    = prod_reg[DIV_S +: T_W];
  assign div_r    = div_x - X_W'(q_est) * X_W'(WINDOW);
  assign avg_next = q_est + T_W'(div_r >= X_W'(WINDOW));

  assign poly_req.start = (state == S_DIV2);
  assign poly_req.t     = avg_next;

  assign out_free = !out_valid || result.ready;
  assign out_load = ((state == S_POLY && poly_rsp.done) || state == S_HOLD) && out_free;

  irads_poly u_poly (
    .clk (clk),
    .rst (rst),
    .req (poly_req),
    .coef(coef),
    .rsp (poly_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      chan_valid <= '0;
      ring_full  <= '0;
      alpha      <= ALPHA_RST;
      coef       <= COEF_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALPHA:   alpha        <= cfg_data[ALPHA_W-1:0];
          CFG_QUARTIC: coef.quartic <= signed'(cfg_data);
          CFG_CUBIC:   coef.cubic   <= signed'(cfg_data);
          CFG_SQUARE:  coef.square  <= signed'(cfg_data);
          CFG_LINEAR:  coef.linear  <= signed'(cfg_data);
          CFG_OFFSET:  coef.offset  <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_fire && in_ok) begin
            state <= S_RDCH;
          end
        end
        S_RDCH: state <= S_RDWIN;
        S_RDWIN: begin
          chan_valid[ch_idx] <= 1'b1;
          // the write at slot zero completes the first lap of the ring
          if (pos_new == '0) begin
            ring_full[ch_idx] <= 1'b1;
          end
          state <= S_DIV1;
        end
        S_DIV1: state <= S_DIV2;
        S_DIV2: state <= S_POLY;
        S_POLY: begin
          if (poly_rsp.done) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      ch_bit    <= sample.channel;
      ch_idx    <= in_idx;
      volts_reg <= code_to_volts(sample.adc_code);
    end
    if (state == S_RDCH) begin
      lp_reg   <= lp_new;
      sum_old  <= rec_cur.sum;
      pos_new  <= pos_next;
      win_addr <= win_addr_next;
    end
    if (state == S_RDWIN) begin
      sum_reg <= sum_new;
    end
    if (state == S_DIV1) begin
      prod_reg <= PROD_W'(div_x) * PROD_W'(DIV_M);
    end
    if (state == S_DIV2) begin
      avg_reg <= avg_next;
    end
    if (out_load) begin
      out_ch    <= ch_bit;
      out_volts <= avg_reg;
      out_dist  <= poly_rsp.distance;
    end
  end

  // channel records: read on the sample transfer, written back in S_RDWIN
  always_ff @(posedge clk) begin
    if (sample_fire && in_ok) begin
      chan_rd <= chan_mem[in_idx];
    end
    if (state == S_RDWIN) begin
      chan_mem[ch_idx] <= '{lp: lp_reg, sum: sum_new, pos: pos_new};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RDCH) begin
      win_rd <= win_mem[win_addr_next];
    end
    if (state == S_RDWIN) begin
      win_mem[win_addr] <= lp_reg;
    end
  end

  assign result.valid          = out_valid;
  assign result.out_channel    = out_ch;
  assign result.smoothed_volts = out_volts;
  assign result.distance       = out_dist;

endmodule
`default_nettype wire

/* rtl/irads_checker.sv */
`default_nettype none
`include "ir_adc_smoothing_distance_unit_macros.svh"
module irads_checker
  import irads_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     sample_valid,
  input logic                     sample_ready,
  input logic                     sample_channel,
  input logic                     result_valid,
  input logic                     result_ready,
  input logic                     result_out_channel,
  input logic [VOLTS_W-1:0]       result_smoothed_volts,
  input logic signed [DIST_W-1:0] result_distance
);

  `IRADS_ASSERT_ALWAYS(reset_empties_output, clk, $past(rst) |-> !result_valid, "result valid right after reset")

  `IRADS_ASSERT(stalled_result_holds, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result_out_channel) && $stable(result_smoothed_volts) && $stable(result_distance), "stalled result changed")

  `IRADS_ASSERT(result_in_range, clk, rst, result_valid |-> (result_smoothed_volts <= VOLTS_W'(VOLTS_FULL)) && (int'(result_out_channel) < CHANNELS), "result voltage or channel out of range")

  `IRADS_ASSERT(one_sample_at_a_time, clk, rst, sample_valid && sample_ready && (int'(sample_channel) < CHANNELS) |=> !sample_ready, "sample taken while another is in work")

endmodule

bind ir_adc_smoothing_distance_unit irads_checker #(.CHANNELS(CHANNELS)) u_irads_checker (
  .clk                  (clk),
  .rst                  (rst),
  .sample_valid         (sample.valid),
  .sample_ready         (sample.ready),
  .sample_channel       (sample.channel),
  .result_valid         (result.valid),
  .result_ready         (result.ready),
  .result_out_channel   (result.out_channel),
  .result_smoothed_volts(result.smoothed_volts),
  .result_distance      (result.distance)
);
`default_nettype wire
